/* rtl/core/ranged_bit_stream_writer_macros.svh */
// ranged_bit_stream_writer_macros.svh: assertion macros for the bit stream writer
// no dependencies; included by files that carry concurrent assertions
`ifndef RANGED_BIT_STREAM_WRITER_MACROS_SVH
`define RANGED_BIT_STREAM_WRITER_MACROS_SVH

// condition holds at every edge outside reset
`define RBSW_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define RBSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RBSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rbsw_pkg.sv */
// rbsw_pkg: shared types and constants of the ranged bit stream writer
// no dependencies; imported by front, queue, back and top level
package rbsw_pkg;

	typedef enum logic [1:0] {
		MODE_RAW      = 2'd0,
		MODE_UNSIGNED = 2'd1,
		MODE_SIGNED   = 2'd2,
		MODE_FLUSH    = 2'd3
	} mode_t;

	localparam logic [4:0] TAG_U_OUTER = 5'hC;
	localparam logic [4:0] TAG_U_INNER = 5'h8;
	localparam logic [4:0] TAG_S_OUTER = 5'hB;
	localparam logic [4:0] TAG_S_INNER = 5'h7;

	localparam logic [5:0] TAG_BITS    = 6'd5;
	localparam logic [5:0] WORD_BITS   = 6'd32;
	localparam logic [6:0] PREFIX_BITS = 7'd79;

	// segment sequence of one write
	localparam logic [2:0] SEG_OUTER    = 3'd0;
	localparam logic [2:0] SEG_INNER_LO = 3'd1;
	localparam logic [2:0] SEG_LO       = 3'd2;
	localparam logic [2:0] SEG_INNER_HI = 3'd3;
	localparam logic [2:0] SEG_HI       = 3'd4;
	localparam logic [2:0] SEG_DATA     = 3'd5;
	localparam logic [2:0] SEG_DONE     = 3'd6;

	typedef struct packed {
		logic        flush;
		logic        with_tags;
		logic        sgn;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] data;
		logic [5:0]  width;
	} entry_t;

	typedef struct packed {
		logic       busy;
		logic [5:0] cnt;
	} back_status_t;

endpackage

/* rtl/core/rbsw_front.sv */
// rbsw_front: accepts input beats, clamps ranged values and sizes every write
// depends on rbsw_pkg; feeds rbsw_queue
module rbsw_front import rbsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        type_checked,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic [5:0]  bit_count,
	input  logic        tag_request,
	output entry_t      push_entry,
	output logic        push_valid,
	input  logic        push_ready
);

	function automatic logic [4:0] lead_one(input logic [31:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	logic        v_s1, v_s2;
	mode_t       mode_s1, mode_s2;
	logic [31:0] value_s1, lo_s1, hi_s1;
	logic [5:0]  cnt_s1;
	logic        tagged_s1, tagged_s2;
	logic [31:0] lo_s2, hi_s2, clamp_s2, diff_s2;
	logic [5:0]  rawcnt_s2;

	logic        take_s2, adv_s1, accept;
	logic [31:0] flip, kv, kl, kh, clamp_n;
	logic [5:0]  rawcnt_n;

	assign take_s2  = !v_s2 || push_ready;
	assign adv_s1   = v_s1 && take_s2;
	assign in_ready = !v_s1 || take_s2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (take_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(mode);
			value_s1  <= value;
			lo_s1     <= range_low;
			hi_s1     <= range_high;
			cnt_s1    <= bit_count;
			tagged_s1 <= type_checked &&
				((mode_t'(mode) == MODE_SIGNED) ||
				 (mode_t'(mode) == MODE_UNSIGNED && tag_request));
		end
	end

	// clamp in offset-binary so one unsigned compare serves both modes
	always_comb begin
		flip = (mode_s1 == MODE_SIGNED) ? 32'h8000_0000 : 32'h0;
		kv   = value_s1 ^ flip;
		kl   = lo_s1 ^ flip;
		kh   = hi_s1 ^ flip;
		priority if (mode_s1 == MODE_RAW) clamp_n = value_s1;
		else if (kv > kh)                 clamp_n = hi_s1;
		else if (kv < kl)                 clamp_n = lo_s1;
		else                              clamp_n = value_s1;
		rawcnt_n = (cnt_s1 > WORD_BITS) ? WORD_BITS : cnt_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mode_s2   <= mode_s1;
			tagged_s2 <= tagged_s1;
			lo_s2     <= lo_s1;
			hi_s2     <= hi_s1;
			clamp_s2  <= clamp_n;
			diff_s2   <= hi_s1 - lo_s1;
			rawcnt_s2 <= rawcnt_n;
		end
	end

	always_comb begin
		push_entry.flush     = (mode_s2 == MODE_FLUSH);
		push_entry.with_tags = tagged_s2;
		push_entry.sgn       = (mode_s2 == MODE_SIGNED);
		push_entry.lo        = lo_s2;
		push_entry.hi        = hi_s2;
		unique case (mode_s2)
			MODE_RAW: begin
				push_entry.data  = clamp_s2;
				push_entry.width = rawcnt_s2;
			end
			MODE_UNSIGNED, MODE_SIGNED: begin
				push_entry.data  = clamp_s2 - lo_s2;
				push_entry.width = (diff_s2 == 32'h0) ? 6'd0
					: ({1'b0, lead_one(diff_s2)} + 6'd1);
			end
			MODE_FLUSH: begin
				push_entry.data  = '0;
				push_entry.width = '0;
			end
		endcase
	end

	assign push_valid = v_s2;

endmodule

/* rtl/core/rbsw_queue.sv */
// rbsw_queue: short queue of sized writes between front and back
// depends on rbsw_pkg
module rbsw_queue import rbsw_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t push_entry,
	input  logic   push_valid,
	output logic   push_ready,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty,
	output logic   full
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	entry_t          slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push;

	assign full       = (cnt_q == FullCnt);
	assign empty      = (cnt_q == '0);
	assign push_ready = !full;
	assign push       = push_valid && !full;
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

/* rtl/core/rbsw_back.sv */
// rbsw_back: appends the segments of each write to the bit accumulator
// one byte out per cycle while out_ready is high; depends on rbsw_pkg; drains rbsw_queue
module rbsw_back import rbsw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  entry_t       q_entry,
	input  logic         q_empty,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         last,
	output back_status_t status
);

	logic        busy_q;
	entry_t      ent_q;
	logic [2:0]  seg_q;
	logic [39:0] acc_q;
	logic [5:0]  cnt_q;
	logic [3:0]  nbytes_q;
	logic        out_valid_q, last_q;
	logic [7:0]  out_byte_q;

	logic        seg_rem, emit, append, done;
	logic [4:0]  outer, inner;
	logic [31:0] seg_val, seg_mask;
	logic [5:0]  seg_w, cnt_e, cnt_n;
	logic [39:0] acc_e, acc_n;
	logic [6:0]  tot_bits;

	assign outer = ent_q.sgn ? TAG_S_OUTER : TAG_U_OUTER;
	assign inner = ent_q.sgn ? TAG_S_INNER : TAG_U_INNER;

	always_comb begin
		unique case (seg_q)
			SEG_OUTER: begin
				seg_val = {27'h0, outer};
				seg_w   = TAG_BITS;
			end
			SEG_INNER_LO, SEG_INNER_HI: begin
				seg_val = {27'h0, inner};
				seg_w   = TAG_BITS;
			end
			SEG_LO: begin
				seg_val = ent_q.lo;
				seg_w   = WORD_BITS;
			end
			SEG_HI: begin
				seg_val = ent_q.hi;
				seg_w   = WORD_BITS;
			end
			SEG_DATA: begin
				seg_val = ent_q.data;
				seg_w   = ent_q.width;
			end
			default: begin
				seg_val = '0;
				seg_w   = '0;
			end
		endcase
	end

	assign seg_mask = seg_w[5] ? '1 : ((32'd1 << seg_w[4:0]) - 32'd1);
	// a zero-width data segment is skipped
	assign seg_rem  = busy_q && ((seg_q < SEG_DATA) ||
		(seg_q == SEG_DATA && ent_q.width != 6'd0));
	assign emit     = (cnt_q >= 6'd8) && (!out_valid_q || out_ready);
	assign cnt_e    = emit ? cnt_q - 6'd8 : cnt_q;
	assign acc_e    = emit ? (acc_q >> 8) : acc_q;
	assign append   = seg_rem && (cnt_e < 6'd8);
	assign acc_n    = append ? (acc_e | ({8'h0, seg_val & seg_mask} << cnt_e[2:0])) : acc_e;
	assign cnt_n    = append ? cnt_e + seg_w : cnt_e;
	assign done     = busy_q && !seg_rem && (cnt_e < 6'd8);
	assign q_pop    = !busy_q && !q_empty;
	assign tot_bits = {1'b0, cnt_q} + (q_entry.with_tags ? PREFIX_BITS : 7'd0)
		+ {1'b0, q_entry.width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			seg_q       <= SEG_DONE;
			acc_q       <= '0;
			cnt_q       <= '0;
			nbytes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				if (q_entry.flush) begin
					// pad the partial byte with zeros already held above the count
					seg_q    <= SEG_DONE;
					cnt_q    <= (cnt_q != 6'd0) ? 6'd8 : 6'd0;
					nbytes_q <= (cnt_q != 6'd0) ? 4'd1 : 4'd0;
				end else begin
					seg_q    <= q_entry.with_tags ? SEG_OUTER : SEG_DATA;
					nbytes_q <= tot_bits[6:3];
				end
			end else begin
				if (done) busy_q <= 1'b0;
				if (append) seg_q <= seg_q + 3'd1;
				acc_q <= acc_n;
				cnt_q <= cnt_n;
				if (emit) nbytes_q <= nbytes_q - 4'd1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_entry;
		if (emit) begin
			out_byte_q <= acc_q[7:0];
			last_q     <= (nbytes_q == 4'd1);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last        = last_q;
	assign status.busy = busy_q;
	assign status.cnt  = cnt_q;

endmodule

/* rtl/core/ranged_bit_stream_writer.sv */
// ranged_bit_stream_writer: top level, config register and front/queue/back wiring
// depends on rbsw_pkg, rbsw_front, rbsw_queue, rbsw_back, ranged_bit_stream_writer_macros.svh
//
// channel  direction  handshake                 beat
// cfg      in         cfg_wr_en                 cfg_wr_data (type_checked)
// in       in         in_valid / in_ready       mode value range_low range_high bit_count tag_request
// out      out        out_valid / out_ready     out_byte last
//
// the front takes one beat per cycle while the queue has room: two stages clamp and size the
// write, then a queue. the back loads a write from the queue, then puts out one byte per cycle
// while out_ready is high. reset clears the partial byte and type_checked; no clearing pass.
// out_ready low stalls the back only; the front keeps accepting until the queue fills.
`include "ranged_bit_stream_writer_macros.svh"
module ranged_bit_stream_writer import rbsw_pkg::*; #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic [5:0]  bit_count,
	input  logic        tag_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic         type_checked_q;
	entry_t       push_entry, pop_entry;
	logic         push_valid, push_ready, pop, q_empty, q_full;
	back_status_t back_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_checked_q <= 1'b0;
		end else if (cfg_wr_en) begin
			type_checked_q <= cfg_wr_data;
		end
	end

	rbsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.type_checked (type_checked_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.value        (value),
		.range_low    (range_low),
		.range_high   (range_high),
		.bit_count    (bit_count),
		.tag_request  (tag_request),
		.push_entry   (push_entry),
		.push_valid   (push_valid),
		.push_ready   (push_ready)
	);

	rbsw_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty),
		.full       (q_full)
	);

	rbsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_entry   (pop_entry),
		.q_empty   (q_empty),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.status    (back_st)
	);

	`RBSW_ASSERT_ALWAYS(a_queue_flags, clk, arst_n, !(q_full && q_empty), "queue full and empty")
	`RBSW_ASSERT_IMPLY(a_idle_partial, clk, arst_n, !back_st.busy, back_st.cnt < 6'd8, "idle with whole byte")
	`RBSW_ASSERT_NEXT(a_pop_loads, clk, arst_n, pop, back_st.busy, "pop did not load back end")

endmodule
